// ===== rtl/lbp_3x3_code_stream_assert.svh =====
// Assertion macros shared by the checker of the 3x3 LBP code stream.
`ifndef LBP_3X3_CODE_STREAM_ASSERT_SVH
`define LBP_3X3_CODE_STREAM_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LBP_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lbp_3x3_code_stream: assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define LBP_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lbp_3x3_code_stream: assertion failed");

`endif

// ===== rtl/lbp_pkg.sv =====
// Package with constants and types of the 3x3 LBP code stream.
`timescale 1ns / 1ps
package lbp_pkg;

	localparam int MAX_LINE    = 1024;
	localparam int PIXEL_BITS  = 8;
	localparam int CODE_BITS   = 8;
	localparam int COL_BITS    = $clog2(MAX_LINE);
	localparam int FILL_BITS   = COL_BITS + 1;
	localparam int WIDTH_BITS  = 11;
	localparam int HEIGHT_BITS = 16;
	localparam int LINE_WORD   = 2 * PIXEL_BITS;
	localparam int WIN_CELLS   = 6;

	localparam int Q_DEPTH    = 4;
	localparam int Q_PTR_BITS = $clog2(Q_DEPTH);
	localparam int Q_CNT_BITS = $clog2(Q_DEPTH + 1);

	localparam int APB_DATA_BITS = 32;
	localparam int ADDR_BITS     = 3;
	localparam int REG_SEL_BIT   = 2;

	// Register indexes, taken from the word address.
	localparam logic REG_LINE_WIDTH   = 1'b0;
	localparam logic REG_FRAME_HEIGHT = 1'b1;

	localparam logic [WIDTH_BITS-1:0]  LINE_WIDTH_RST   = 11'd640;
	localparam logic [HEIGHT_BITS-1:0] FRAME_HEIGHT_RST = 16'd480;
	localparam logic [WIDTH_BITS-1:0]  WIDTH_MIN        = 11'd3;
	localparam logic [HEIGHT_BITS-1:0] HEIGHT_MIN       = 16'd3;

	typedef struct packed {
		logic [WIDTH_BITS-1:0]  line_width;
		logic [HEIGHT_BITS-1:0] frame_height;
	} lbp_cfg_t;

	// One classified pixel with its column from the line stores.
	typedef struct packed {
		logic [PIXEL_BITS-1:0] pixel;
		logic [PIXEL_BITS-1:0] top;
		logic [PIXEL_BITS-1:0] mid;
		logic                  emit;
		logic                  row_end;
		logic                  frame_end;
	} lbp_item_t;

endpackage

// ===== rtl/lbp_stream_if.sv =====
// Stream interfaces for pixels in and LBP codes out.
`timescale 1ns / 1ps
interface lbp_pix_if;
	import lbp_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [PIXEL_BITS-1:0] pixel;
	modport source (output valid, output pixel, input ready);
	modport sink (input valid, input pixel, output ready);
endinterface

interface lbp_code_if;
	import lbp_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [CODE_BITS-1:0] lbp_code;
	logic                 last_in_row;
	logic                 last_in_frame;
	modport source (output valid, output lbp_code, output last_in_row, output last_in_frame,
		input ready);
	modport sink (input valid, input lbp_code, input last_in_row, input last_in_frame,
		output ready);
endinterface

// ===== rtl/lbp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module lbp_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

// ===== rtl/lbp_front.sv =====
// Front end: accepts pixels, tracks position, reads and updates the line stores.
`timescale 1ns / 1ps
module lbp_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  lbp_pkg::lbp_cfg_t              cfg,
	lbp_pix_if.sink                        pixels,
	input  logic [lbp_pkg::Q_CNT_BITS-1:0] q_level,
	output logic                           push,
	output lbp_pkg::lbp_item_t             push_item
);
	import lbp_pkg::*;

	logic [COL_BITS-1:0]    col_q;
	logic [HEIGHT_BITS-1:0] row_q;
	logic [FILL_BITS-1:0]   fill_q;

	logic                  valid_s1;
	logic [PIXEL_BITS-1:0] pixel_s1;
	logic [COL_BITS-1:0]   addr_s1;
	logic                  written_s1;
	logic                  emit_s1;
	logic                  row_end_s1;
	logic                  frame_end_s1;

	logic [WIDTH_BITS-1:0]  w_eff;
	logic [WIDTH_BITS-1:0]  w_last;
	logic [HEIGHT_BITS-1:0] h_last;
	logic                   row_end;
	logic                   frame_end;
	logic                   emit;
	logic                   accept;
	logic [Q_CNT_BITS:0]    in_flight;
	logic [LINE_WORD-1:0]   rd_word;
	logic [PIXEL_BITS-1:0]  top;
	logic [PIXEL_BITS-1:0]  mid;

	always_comb begin
		if (cfg.line_width < WIDTH_MIN) begin
			w_eff = WIDTH_MIN;
		end else if (cfg.line_width > WIDTH_BITS'(MAX_LINE)) begin
			w_eff = WIDTH_BITS'(MAX_LINE);
		end else begin
			w_eff = cfg.line_width;
		end
		w_last = w_eff - WIDTH_BITS'(1);
		if (cfg.frame_height < HEIGHT_MIN) begin
			h_last = HEIGHT_MIN - HEIGHT_BITS'(1);
		end else begin
			h_last = cfg.frame_height - HEIGHT_BITS'(1);
		end
	end

	assign row_end   = WIDTH_BITS'(col_q) >= w_last;
	assign frame_end = row_q >= h_last;
	assign emit      = (row_q >= HEIGHT_BITS'(2)) && (col_q >= COL_BITS'(2));

	// Room is kept in the queue for the pixel still in the read stage.
	assign in_flight    = {1'b0, q_level} + (Q_CNT_BITS + 1)'(valid_s1);
	assign pixels.ready = in_flight < (Q_CNT_BITS + 1)'(Q_DEPTH);
	assign accept       = pixels.valid && pixels.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			valid_s1 <= 1'b0;
			fill_q   <= '0;
		end else begin
			valid_s1 <= accept;
			if (accept) begin
				if (row_end) begin
					col_q <= '0;
					row_q <= frame_end ? '0 : row_q + HEIGHT_BITS'(1);
				end else begin
					col_q <= col_q + COL_BITS'(1);
				end
			end
			if (valid_s1 && (FILL_BITS'(addr_s1) == fill_q)) begin
				fill_q <= fill_q + FILL_BITS'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pixel_s1     <= pixels.pixel;
			addr_s1      <= col_q;
			written_s1   <= FILL_BITS'(col_q) < fill_q;
			emit_s1      <= emit;
			row_end_s1   <= row_end;
			frame_end_s1 <= frame_end;
		end
	end

	lbp_ram #(
		.WIDTH(LINE_WORD),
		.DEPTH(MAX_LINE)
	) u_line_ram (
		.clk  (clk),
		.we   (valid_s1),
		.waddr(addr_s1),
		.wdata({mid, pixel_s1}),
		.re   (accept),
		.raddr(col_q),
		.rdata(rd_word)
	);

	// Entries beyond the written prefix read as zero; the RAM itself is never cleared.
	assign top = written_s1 ? rd_word[LINE_WORD-1:PIXEL_BITS] : '0;
	assign mid = written_s1 ? rd_word[PIXEL_BITS-1:0] : '0;

	assign push = valid_s1;
	always_comb begin
		push_item.pixel     = pixel_s1;
		push_item.top       = top;
		push_item.mid       = mid;
		push_item.emit      = emit_s1;
		push_item.row_end   = row_end_s1;
		push_item.frame_end = frame_end_s1;
	end
endmodule

// ===== rtl/lbp_queue.sv =====
// Short queue of classified pixels between the front and back ends.
`timescale 1ns / 1ps
module lbp_queue (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	input  lbp_pkg::lbp_item_t             push_item,
	input  logic                           pop,
	output lbp_pkg::lbp_item_t             head_item,
	output logic                           not_empty,
	output logic [lbp_pkg::Q_CNT_BITS-1:0] level
);
	import lbp_pkg::*;

	lbp_item_t             entry_q [Q_DEPTH];
	logic [Q_PTR_BITS-1:0] wr_ptr_q;
	logic [Q_PTR_BITS-1:0] rd_ptr_q;
	logic [Q_CNT_BITS-1:0] level_q;

	function automatic logic [Q_PTR_BITS-1:0] ptr_inc(input logic [Q_PTR_BITS-1:0] p);
		logic [Q_PTR_BITS-1:0] n;
		n = (p == Q_PTR_BITS'(Q_DEPTH - 1)) ? '0 : p + Q_PTR_BITS'(1);
		return n;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (push && !pop) begin
				level_q <= level_q + Q_CNT_BITS'(1);
			end else if (pop && !push) begin
				level_q <= level_q - Q_CNT_BITS'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	assign head_item = entry_q[rd_ptr_q];
	assign not_empty = level_q != '0;
	assign level     = level_q;
endmodule

// ===== rtl/lbp_back.sv =====
// Back end: slides the 3x3 window, forms the LBP code and holds the output.
`timescale 1ns / 1ps
module lbp_back (
	input  logic               clk,
	input  logic               arst_n,
	input  lbp_pkg::lbp_item_t head_item,
	input  logic               not_empty,
	output logic               pop,
	lbp_code_if.source         codes
);
	import lbp_pkg::*;

	// Cells 0..2: column c-2 top, middle, bottom; cells 3..5: column c-1.
	logic [PIXEL_BITS-1:0] win_q [WIN_CELLS];
	logic                  out_valid_q;
	logic [CODE_BITS-1:0]  code_q;
	logic                  last_row_q;
	logic                  last_frame_q;
	logic [CODE_BITS-1:0]  code;
	logic [PIXEL_BITS-1:0] ctr;

	assign pop = not_empty && (!out_valid_q || codes.ready);
	assign ctr = win_q[4];

	always_comb begin
		code[7] = win_q[0] > ctr;
		code[6] = win_q[3] > ctr;
		code[5] = head_item.top > ctr;
		code[4] = head_item.mid > ctr;
		code[3] = head_item.pixel > ctr;
		code[2] = win_q[5] > ctr;
		code[1] = win_q[2] > ctr;
		code[0] = win_q[1] > ctr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			for (int i = 0; i < WIN_CELLS; i++) begin
				win_q[i] <= '0;
			end
		end else begin
			if (pop && head_item.emit) begin
				out_valid_q <= 1'b1;
			end else if (codes.ready) begin
				out_valid_q <= 1'b0;
			end
			if (pop) begin
				win_q[0] <= win_q[3];
				win_q[1] <= win_q[4];
				win_q[2] <= win_q[5];
				win_q[3] <= head_item.top;
				win_q[4] <= head_item.mid;
				win_q[5] <= head_item.pixel;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && head_item.emit) begin
			code_q       <= code;
			last_row_q   <= head_item.row_end;
			last_frame_q <= head_item.row_end && head_item.frame_end;
		end
	end

	assign codes.valid         = out_valid_q;
	assign codes.lbp_code      = code_q;
	assign codes.last_in_row   = last_row_q;
	assign codes.last_in_frame = last_frame_q;
endmodule

// ===== rtl/lbp_3x3_code_stream.sv =====
// Top level of the streaming 3x3 local binary pattern code generator.
//
//  Channel   Direction  Carries                                  Handshake
//  pixels    in         pixel[7:0], raster order                 valid / ready
//  codes     out        lbp_code[7:0], last_in_row, last_in_frame valid / ready
//  APB       in         line_width (0x0), frame_height (0x4)     psel / penable, pready = 1
//
// One pixel request is taken per clock for as long as the code channel drains; the
// line-store RAM, reading the current column while writing back the previous one, sets that.
// A code is registered on the output as the pixel that completes its window leaves the queue.
// A four-entry queue sits between front and back; pixel ready falls once the queue plus the
// pixel in the read stage fill it, so a stalled output holds the input. Reset is asynchronous
// and needs no clearing pass: a fill count marks the written part of the line stores.
`timescale 1ns / 1ps
module lbp_3x3_code_stream (
	input  logic                              clk,
	input  logic                              arst_n,
	lbp_pix_if.sink                           pixels,
	lbp_code_if.source                        codes,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [lbp_pkg::ADDR_BITS-1:0]     paddr,
	input  logic [lbp_pkg::APB_DATA_BITS-1:0] pwdata,
	output logic [lbp_pkg::APB_DATA_BITS-1:0] prdata,
	output logic                              pready
);
	import lbp_pkg::*;

	lbp_cfg_t              cfg_q;
	logic                  cfg_wr;
	logic                  push;
	lbp_item_t             push_item;
	logic                  pop;
	lbp_item_t             head_item;
	logic                  not_empty;
	logic [Q_CNT_BITS-1:0] q_level;

	// The register is picked by the word address alone; byte offsets are ignored.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.line_width   <= LINE_WIDTH_RST;
			cfg_q.frame_height <= FRAME_HEIGHT_RST;
		end else if (cfg_wr) begin
			case (paddr[REG_SEL_BIT])
				REG_LINE_WIDTH: begin
					cfg_q.line_width <= pwdata[WIDTH_BITS-1:0];
				end
				REG_FRAME_HEIGHT: begin
					cfg_q.frame_height <= pwdata[HEIGHT_BITS-1:0];
				end
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	always_comb begin
		case (paddr[REG_SEL_BIT])
			REG_LINE_WIDTH: begin
				prdata = APB_DATA_BITS'(cfg_q.line_width);
			end
			REG_FRAME_HEIGHT: begin
				prdata = APB_DATA_BITS'(cfg_q.frame_height);
			end
			default: begin
				prdata = '0;
			end
		endcase
	end

	// Front end: position counters, border classification and the line stores.
	lbp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.pixels   (pixels),
		.q_level  (q_level),
		.push     (push),
		.push_item(push_item)
	);

	lbp_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_item(push_item),
		.pop      (pop),
		.head_item(head_item),
		.not_empty(not_empty),
		.level    (q_level)
	);

	// Back end: the window slides on every pixel, border or not, and codes are
	// registered only for pixels that complete a window.
	lbp_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head_item(head_item),
		.not_empty(not_empty),
		.pop      (pop),
		.codes    (codes)
	);
endmodule

// ===== rtl/lbp_3x3_code_stream_checker.sv =====
// Port-level checker for the 3x3 LBP code stream, bound to the top level.
`timescale 1ns / 1ps
`include "lbp_3x3_code_stream_assert.svh"
module lbp_3x3_code_stream_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [7:0]  out_code,
	input logic        out_last_row,
	input logic        out_last_frame,
	input logic        psel,
	input logic        penable,
	input logic        pwrite,
	input logic [2:0]  paddr,
	input logic [31:0] pwdata,
	input logic [31:0] prdata
);
	// Pixels accepted less codes delivered; a code never outruns its pixels.
	logic [31:0] pend_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + 32'(in_valid && in_ready) - 32'(out_valid && out_ready);
		end
	end

	`LBP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_code) && $stable(out_last_row) && $stable(out_last_frame))
	`LBP_ASSERT_NOW(a_frame_implies_row, out_valid, !out_last_frame || out_last_row)
	`LBP_ASSERT_NOW(a_code_has_source, out_valid && out_ready, pend_q != 32'd0)
	`LBP_ASSERT_NEXT(a_width_readback, psel && penable && pwrite && !paddr[2], paddr[2] || (prdata[10:0] == $past(pwdata[10:0])))
endmodule

bind lbp_3x3_code_stream lbp_3x3_code_stream_checker u_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (pixels.valid),
	.in_ready      (pixels.ready),
	.out_valid     (codes.valid),
	.out_ready     (codes.ready),
	.out_code      (codes.lbp_code),
	.out_last_row  (codes.last_in_row),
	.out_last_frame(codes.last_in_frame),
	.psel          (psel),
	.penable       (penable),
	.pwrite        (pwrite),
	.paddr         (paddr),
	.pwdata        (pwdata),
	.prdata        (prdata)
);

// ===== tb/tb_lbp_3x3_code_stream.sv =====
// Self-checking testbench for the streaming 3x3 local binary pattern code generator.
`timescale 1ns / 1ps
module tb_lbp_3x3_code_stream;
	import lbp_pkg::*;

	// Least number of random pixel requests before the wide-row and final phases.
	localparam int unsigned RANDOM_ITEMS = 250;
	// Cycles allowed after the last expected code before the block counts as idle. A pixel
	// that completes no window can still be in the read stage or the queue at that point.
	localparam int unsigned DRAIN_CYCLES = 12;

	// One predicted code, in the same field order as the code channel.
	typedef struct packed {
		logic [CODE_BITS-1:0] code;
		logic                 last_in_row;
		logic                 last_in_frame;
	} lbp_result_t;

	// How a directed row is checked: against the predictor, as a pixel that must give no
	// code, or against the code typed into the row.
	typedef enum logic [1:0] {ROW_PREDICT, ROW_SILENT, ROW_CODE} row_kind_t;

	typedef struct packed {
		logic [PIXEL_BITS-1:0] pixel;
		row_kind_t             kind;
		lbp_result_t           result;
	} stim_row_t;

	typedef enum logic [1:0] {PIX_FULL, PIX_NARROW, PIX_EXTREME} pix_style_t;

	localparam lbp_result_t NO_CODE = '0;

	// Three 3x3 frames, run with line_width = frame_height = 3. The first has a black centre
	// under a white ring, so every neighbour wins; the second is the reverse, so none does.
	// The third mixes near and equal values around the centre and is left to the predictor.
	localparam stim_row_t DIRECTED_ROWS [27] = '{
		'{8'd255, ROW_SILENT, NO_CODE}, '{8'd255, ROW_SILENT, NO_CODE},
		'{8'd255, ROW_SILENT, NO_CODE}, '{8'd255, ROW_SILENT, NO_CODE},
		'{8'd0,   ROW_SILENT, NO_CODE}, '{8'd255, ROW_SILENT, NO_CODE},
		'{8'd255, ROW_SILENT, NO_CODE}, '{8'd255, ROW_SILENT, NO_CODE},
		'{8'd255, ROW_CODE,   '{8'hFF, 1'b1, 1'b1}},
		'{8'd0,   ROW_SILENT, NO_CODE}, '{8'd0,   ROW_SILENT, NO_CODE},
		'{8'd0,   ROW_SILENT, NO_CODE}, '{8'd0,   ROW_SILENT, NO_CODE},
		'{8'd255, ROW_SILENT, NO_CODE}, '{8'd0,   ROW_SILENT, NO_CODE},
		'{8'd0,   ROW_SILENT, NO_CODE}, '{8'd0,   ROW_SILENT, NO_CODE},
		'{8'd0,   ROW_CODE,   '{8'h00, 1'b1, 1'b1}},
		'{8'd129, ROW_PREDICT, NO_CODE}, '{8'd128, ROW_PREDICT, NO_CODE},
		'{8'd255, ROW_PREDICT, NO_CODE}, '{8'd254, ROW_PREDICT, NO_CODE},
		'{8'd128, ROW_PREDICT, NO_CODE}, '{8'd0,   ROW_PREDICT, NO_CODE},
		'{8'd1,   ROW_PREDICT, NO_CODE}, '{8'd200, ROW_PREDICT, NO_CODE},
		'{8'd127, ROW_PREDICT, NO_CODE}
	};

	logic clk;
	logic arst_n;

	lbp_pix_if  pix_ch ();
	lbp_code_if code_ch ();

	logic                     psel;
	logic                     penable;
	logic                     pwrite;
	logic [ADDR_BITS-1:0]     paddr;
	logic [APB_DATA_BITS-1:0] pwdata;
	logic [APB_DATA_BITS-1:0] prdata;
	logic                     pready;

	lbp_3x3_code_stream u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.pixels  (pix_ch),
		.codes   (code_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// Shadow of the block: both registers, both line stores, the six window cells and the
	// two position counters. It is advanced once for every accepted pixel request.
	logic [WIDTH_BITS-1:0]  cfg_width;
	logic [HEIGHT_BITS-1:0] cfg_height;
	logic [PIXEL_BITS-1:0]  line_two_up [MAX_LINE];
	logic [PIXEL_BITS-1:0]  line_one_up [MAX_LINE];
	logic [PIXEL_BITS-1:0]  win_px [WIN_CELLS];
	int unsigned            col_pos;
	logic [HEIGHT_BITS-1:0] row_pos;

	// Codes predicted but not yet seen on the code channel, oldest first.
	lbp_result_t due_codes [$];
	lbp_result_t oldest_code;

	int unsigned errors;
	int unsigned pixels_sent;
	int unsigned codes_seen;
	int unsigned frames_seen;
	int unsigned reg_writes;

	// Percent chances that the pixel sender starts a gap before a request, and that the code receiver starts one.
	int unsigned idle_pct;
	int unsigned stall_pct;
	int unsigned stall_left;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// A hung handshake ends the run here.
	initial begin
		#5_000_000;
		$display("tb_lbp_3x3_code_stream: done, errors");
		$finish;
	end

	// The block clamps the row length to [3, MAX_LINE] and lifts the frame height to at least
	// three rows, whatever the registers hold.
	function automatic int unsigned eff_width();
		if (cfg_width < WIDTH_MIN)
			return WIDTH_MIN;
		if (cfg_width > MAX_LINE)
			return MAX_LINE;
		return cfg_width;
	endfunction

	function automatic int unsigned eff_height();
		if (cfg_height < HEIGHT_MIN)
			return HEIGHT_MIN;
		return cfg_height;
	endfunction

	// Advances the shadow by one pixel and returns 1 when that pixel completes a window.
	// The centre is the middle cell of the previous column; each code bit compares one of
	// the eight neighbours with it, top-left first and then clockwise round to the left.
	function automatic bit lbp_window_step(input logic [PIXEL_BITS-1:0] p,
			output lbp_result_t res);
		int unsigned           w;
		int unsigned           h;
		int unsigned           c;
		int unsigned           r;
		int unsigned           slot;
		logic [PIXEL_BITS-1:0] top;
		logic [PIXEL_BITS-1:0] mid;
		logic [PIXEL_BITS-1:0] ctr;
		bit                    row_end;
		bit                    frame_end;
		bit                    emit;
		w = eff_width();
		h = eff_height();
		c = col_pos;
		r = row_pos;
		slot = c % MAX_LINE;
		top = line_two_up[slot];
		mid = line_one_up[slot];
		// A counter left beyond the end by a register change still ends the row or frame.
		row_end = (c >= w - 1);
		frame_end = (r >= h - 1);
		line_two_up[slot] = mid;
		line_one_up[slot] = p;
		emit = (r >= 2) && (c >= 2);
		res = NO_CODE;
		if (emit) begin
			ctr = win_px[4];
			res.code = {win_px[0] > ctr, win_px[3] > ctr, top > ctr, mid > ctr,
				p > ctr, win_px[5] > ctr, win_px[2] > ctr, win_px[1] > ctr};
			res.last_in_row = row_end;
			res.last_in_frame = row_end && frame_end;
		end
		win_px[0] = win_px[3];
		win_px[1] = win_px[4];
		win_px[2] = win_px[5];
		win_px[3] = top;
		win_px[4] = mid;
		win_px[5] = p;
		if (row_end) begin
			col_pos = 0;
			row_pos = frame_end ? '0 : row_pos + 1'b1;
		end else begin
			col_pos = c + 1;
		end
		return emit;
	endfunction

	// Pixels still needed to close the current frame under the present settings.
	function automatic int unsigned pixels_to_frame_end();
		int unsigned n;
		int unsigned c;
		int unsigned r;
		n = 0;
		c = col_pos;
		r = row_pos;
		forever begin
			n++;
			if (c >= eff_width() - 1) begin
				if (r >= eff_height() - 1)
					return n;
				c = 0;
				r++;
			end else begin
				c++;
			end
		end
	endfunction

	function automatic logic [PIXEL_BITS-1:0] pick_pixel(input pix_style_t style);
		case (style)
			// A narrow band makes equal neighbours common, which must not set a bit.
			PIX_NARROW:  return PIXEL_BITS'($urandom_range(100, 103));
			PIX_EXTREME: return $urandom_range(0, 1) ? '1 : '0;
			default:     return PIXEL_BITS'($urandom);
		endcase
	endfunction

	function automatic int unsigned pick_density();
		case ($urandom_range(0, 2))
			0:       return 0;
			1:       return 8;
			default: return 30;
		endcase
	endfunction

	// Offers one pixel request, possibly after a gap, and waits until the block takes it.
	// The expectation is recorded at the accepting edge, before its code can appear.
	task automatic send_pixel(input logic [PIXEL_BITS-1:0] p, input row_kind_t kind,
			input lbp_result_t typed);
		lbp_result_t predicted;
		bit          has_code;
		if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
			pix_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		pix_ch.valid <= 1'b1;
		pix_ch.pixel <= p;
		do @(posedge clk); while (!pix_ch.ready);
		pixels_sent++;
		has_code = lbp_window_step(p, predicted);
		case (kind)
			ROW_CODE:    due_codes.push_back(typed);
			ROW_PREDICT: if (has_code) due_codes.push_back(predicted);
			default:     ;
		endcase
	endtask

	task automatic run_pixels(input int unsigned n, input pix_style_t style);
		repeat (n) send_pixel(pick_pixel(style), ROW_PREDICT, NO_CODE);
	endtask

	// Holds the sender back until every predicted code has come out, then lets the pipeline
	// empty of pixels that complete no window.
	task automatic settle();
		pix_ch.valid <= 1'b0;
		while (due_codes.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Reads a register back over the configuration port. prdata is taken at the falling edge
	// inside the access cycle, where it is stable whichever way the block produces it.
	task automatic check_reg(input logic idx, input logic [APB_DATA_BITS-1:0] want);
		logic [ADDR_BITS-1:0]     addr;
		logic [APB_DATA_BITS-1:0] got;
		addr = '0;
		addr[REG_SEL_BIT] = idx;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= addr;
		@(posedge clk);
		penable <= 1'b1;
		@(negedge clk);
		got = prdata;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d",
				(idx == REG_LINE_WIDTH) ? "line_width" : "frame_height", want, got);
			errors++;
		end
	endtask

	// Writes a register with a setup and an access cycle, mirrors it in the shadow at the
	// writing edge, and reads it back. Only the register's own bits are kept.
	task automatic set_reg(input logic idx, input logic [APB_DATA_BITS-1:0] value);
		logic [ADDR_BITS-1:0]     addr;
		logic [APB_DATA_BITS-1:0] held;
		addr = '0;
		addr[REG_SEL_BIT] = idx;
		held = '0;
		if (idx == REG_LINE_WIDTH)
			held[WIDTH_BITS-1:0] = value[WIDTH_BITS-1:0];
		else
			held[HEIGHT_BITS-1:0] = value[HEIGHT_BITS-1:0];
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx == REG_LINE_WIDTH)
			cfg_width = held[WIDTH_BITS-1:0];
		else
			cfg_height = held[HEIGHT_BITS-1:0];
		reg_writes++;
		@(posedge clk);
		check_reg(idx, held);
	endtask

	// One random phase: maybe new settings, new gap densities, then a run of pixels. Most
	// phases close the current frame (and often one more), so rows and frames wrap and the
	// last flags are exercised; the rest stop mid-frame, so the next settings land there.
	task automatic random_phase();
		int unsigned pick;
		int unsigned n;
		pix_style_t  style;
		settle();
		if ($urandom_range(0, 3) != 0) begin
			pick = $urandom_range(0, 19);
			if (pick < 14)
				set_reg(REG_LINE_WIDTH, $urandom_range(3, 10));
			else if (pick < 16)
				set_reg(REG_LINE_WIDTH, $urandom_range(0, 2));
			else if (pick < 18)
				set_reg(REG_LINE_WIDTH, $urandom_range(11, 48));
			else if (pick == 18)
				set_reg(REG_LINE_WIDTH, 2047);
			else
				set_reg(REG_LINE_WIDTH, $urandom_range(1025, 2046));
		end
		if ($urandom_range(0, 3) != 0) begin
			pick = $urandom_range(0, 19);
			if (pick < 15)
				set_reg(REG_FRAME_HEIGHT, $urandom_range(3, 6));
			else if (pick < 17)
				set_reg(REG_FRAME_HEIGHT, $urandom_range(0, 2));
			else if (pick < 19)
				set_reg(REG_FRAME_HEIGHT, $urandom_range(7, 12));
			else
				set_reg(REG_FRAME_HEIGHT, 16'hFFFF);
		end
		idle_pct = pick_density();
		stall_pct = pick_density();
		case ($urandom_range(0, 3))
			2:       style = PIX_NARROW;
			3:       style = PIX_EXTREME;
			default: style = PIX_FULL;
		endcase
		// Long rows or tall frames only get a short burst; they are left mid-frame.
		if (eff_width() > 48 || eff_height() > 12)
			n = $urandom_range(1, 64);
		else if ($urandom_range(0, 9) < 7)
			n = pixels_to_frame_end() + ($urandom_range(0, 1) ? eff_width() * eff_height() : 0);
		else
			n = $urandom_range(1, 3 * eff_width());
		run_pixels(n, style);
	endtask

	// Code receiver: ready drops in bursts at the phase's density.
	always @(posedge clk) begin
		if (!arst_n) begin
			code_ch.ready <= 1'b0;
		end else if (stall_left != 0) begin
			code_ch.ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
			code_ch.ready <= 1'b0;
			stall_left <= $urandom_range(0, 5);
		end else begin
			code_ch.ready <= 1'b1;
		end
	end

	// Every accepted code request is matched, field by field, with the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && code_ch.valid && code_ch.ready) begin
			codes_seen++;
			if (code_ch.last_in_frame)
				frames_seen++;
			if (due_codes.size() == 0) begin
				$error("lbp_code: expected none, got %02h", code_ch.lbp_code);
				errors++;
			end else begin
				oldest_code = due_codes.pop_front();
				if (code_ch.lbp_code !== oldest_code.code) begin
					$error("lbp_code: expected %02h, got %02h",
						oldest_code.code, code_ch.lbp_code);
					errors++;
				end
				if (code_ch.last_in_row !== oldest_code.last_in_row) begin
					$error("last_in_row: expected %0b, got %0b",
						oldest_code.last_in_row, code_ch.last_in_row);
					errors++;
				end
				if (code_ch.last_in_frame !== oldest_code.last_in_frame) begin
					$error("last_in_frame: expected %0b, got %0b",
						oldest_code.last_in_frame, code_ch.last_in_frame);
					errors++;
				end
			end
		end
	end

	initial begin
		int unsigned random_start;
		arst_n = 1'b0;
		pix_ch.valid = 1'b0;
		pix_ch.pixel = '0;
		code_ch.ready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		errors = 0;
		pixels_sent = 0;
		codes_seen = 0;
		frames_seen = 0;
		reg_writes = 0;
		idle_pct = 0;
		stall_pct = 0;
		stall_left = 0;
		// The shadow starts from the reset state: default registers, cleared line stores.
		cfg_width = LINE_WIDTH_RST;
		cfg_height = FRAME_HEIGHT_RST;
		for (int i = 0; i < MAX_LINE; i++) begin
			line_two_up[i] = '0;
			line_one_up[i] = '0;
		end
		for (int i = 0; i < WIN_CELLS; i++)
			win_px[i] = '0;
		col_pos = 0;
		row_pos = '0;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Both registers must read back their reset values before anything is written.
		check_reg(REG_LINE_WIDTH, APB_DATA_BITS'(LINE_WIDTH_RST));
		check_reg(REG_FRAME_HEIGHT, APB_DATA_BITS'(FRAME_HEIGHT_RST));

		// Directed frames at the smallest legal size, with light gaps on both sides.
		set_reg(REG_LINE_WIDTH, 3);
		set_reg(REG_FRAME_HEIGHT, 3);
		idle_pct = 20;
		stall_pct = 20;
		foreach (DIRECTED_ROWS[i])
			send_pixel(DIRECTED_ROWS[i].pixel, DIRECTED_ROWS[i].kind, DIRECTED_ROWS[i].result);

		// Register values below the minimum must behave as a 3x3 frame.
		settle();
		set_reg(REG_LINE_WIDTH, 0);
		set_reg(REG_FRAME_HEIGHT, 1);
		run_pixels(pixels_to_frame_end() + 9, PIX_FULL);

		// The widest register value and the tallest frame, left mid-row; narrowing the row
		// then leaves the column counter beyond the new end, which must close the row.
		settle();
		set_reg(REG_LINE_WIDTH, 2047);
		set_reg(REG_FRAME_HEIGHT, 16'hFFFF);
		run_pixels(40, PIX_FULL);
		settle();
		set_reg(REG_LINE_WIDTH, 4);
		run_pixels(13, PIX_FULL);
		// Likewise a lowered height leaves the row counter past the last row, so the row
		// under way ends the frame and its last code carries both flags.
		settle();
		set_reg(REG_FRAME_HEIGHT, 2);
		run_pixels(pixels_to_frame_end() + 12, PIX_FULL);

		random_start = pixels_sent;
		while (pixels_sent < random_start + RANDOM_ITEMS)
			random_phase();

		// One full row at MAX_LINE. The frame is closed at the narrow width and two short
		// rows are sent, so the wide row is the third and every pixel from column 2 on gives
		// a code, reading line-store columns that the short rows never wrote.
		settle();
		set_reg(REG_LINE_WIDTH, 3);
		set_reg(REG_FRAME_HEIGHT, 3);
		idle_pct = pick_density();
		stall_pct = pick_density();
		run_pixels(pixels_to_frame_end() + 6, PIX_FULL);
		settle();
		set_reg(REG_LINE_WIDTH, MAX_LINE);
		run_pixels(MAX_LINE, PIX_FULL);

		// Final stretch at full rate on both sides.
		settle();
		set_reg(REG_LINE_WIDTH, $urandom_range(3, 8));
		set_reg(REG_FRAME_HEIGHT, $urandom_range(3, 5));
		idle_pct = 0;
		stall_pct = 0;
		run_pixels(pixels_to_frame_end() + 2 * eff_width() * eff_height(), PIX_FULL);

		pix_ch.valid <= 1'b0;
		for (int k = 0; k < 4000 && due_codes.size() != 0; k++)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (due_codes.size() != 0) begin
			$error("lbp_code: expected %0d more codes, got none", due_codes.size());
			errors++;
		end

		$display("Sent %0d pixel requests and checked %0d code requests over %0d frames.",
			pixels_sent, codes_seen, frames_seen);
		$display("Made %0d register writes, clamped and mid-frame settings among them.",
			reg_writes);
		if (errors == 0)
			$display("tb_lbp_3x3_code_stream: done, clean");
		else
			$display("tb_lbp_3x3_code_stream: done, errors");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/lbp_pkg.sv
rtl/lbp_stream_if.sv
rtl/lbp_ram.sv
rtl/lbp_front.sv
rtl/lbp_queue.sv
rtl/lbp_back.sv
rtl/lbp_3x3_code_stream.sv
rtl/lbp_3x3_code_stream_checker.sv
tb/tb_lbp_3x3_code_stream.sv
